### design/rlcc_pkg.sv
package rlcc_pkg;

    localparam int LANES   = 4;
    localparam int LANE_W  = 16;
    localparam int WORD_W  = LANES * LANE_W;
    localparam int IDX_W   = 8;
    localparam int PIX_W   = 24;
    localparam int FMT_W   = 4;
    localparam int SUM_W   = LANE_W + 2;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic signed [SUM_W-1:0] LANE_MAX = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] LANE_MIN = -SUM_W'(32768);

    // Register map, word index (paddr[ADDR_W-1:2])
    localparam logic [ADDR_W-3:0] REG_PIXEL_FORMAT = '0;

    typedef enum logic [1:0] {
        OP_CONVERT    = 2'd0,
        OP_TABLE_WR   = 2'd1,
        OP_PALETTE_WR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        SEL_RED   = 2'd0,
        SEL_GREEN = 2'd1,
        SEL_BLUE  = 2'd2
    } table_sel_t;

    typedef enum logic [FMT_W-1:0] {
        FMT_BGR    = 4'd0,
        FMT_RGB    = 4'd1,
        FMT_B5G5R5 = 4'd2,
        FMT_B5G6R5 = 4'd3,
        FMT_GRAY   = 4'd4,
        FMT_INDEX8 = 4'd5,
        FMT_INDEX4 = 4'd6,
        FMT_INDEX2 = 4'd7,
        FMT_INDEX1 = 4'd8
    } fmt_t;

    // One issue slot from the item stage toward the lookup stage
    typedef struct packed {
        logic             enter;        // a pixel or palette write moves to the sum stage
        logic             rd_tables;
        logic             rd_palette;
        logic             from_palette;
        logic             pal_write;
        logic             last;
        logic [IDX_W-1:0] r_addr;
        logic [IDX_W-1:0] g_addr;
        logic [IDX_W-1:0] b_addr;
        logic [IDX_W-1:0] pal_addr;
        logic [IDX_W-1:0] pal_wr_idx;
    } issue_t;

    typedef struct packed {
        logic              en;
        logic [1:0]        sel;
        logic [IDX_W-1:0]  addr;
        logic [WORD_W-1:0] data;
    } tbl_wr_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [WORD_W-1:0] data;
    } pal_wr_t;

endpackage

### design/rgb_lut_color_converter.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  operation, pixel bytes, table select, entry, 4 lanes
// m_        out        m_valid / m_ready  four saturated signed lanes, last pixel flag
// APB       in         psel/penable       pixel_format at byte address 0
//
// Direct formats, table writes and palette writes issue as one item each; an
// indexed byte issues one palette read per packed pixel (1, 2, 4 or 8), set by the
// single palette read port. Items issue only while the sum stage is open.
// Reset (aresetn, synchronous, low) clears control only; the tables and the
// palette hold garbage until written, so no clearing pass runs. A stall on
// m_ready backs up through the sum stage into the item stage.
module rgb_lut_color_converter (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rlcc_pkg::ADDR_W-1:0]           paddr,
    input  logic [rlcc_pkg::DATA_W-1:0]           pwdata,
    output logic [rlcc_pkg::DATA_W-1:0]           prdata,
    output logic                                  pready,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_operation,
    input  logic [rlcc_pkg::PIX_W-1:0]            s_pixel_bytes,
    input  logic [1:0]                            s_table_select,
    input  logic [rlcc_pkg::IDX_W-1:0]            s_entry_index,
    input  logic signed [rlcc_pkg::LANE_W-1:0]    s_lane0_value,
    input  logic signed [rlcc_pkg::LANE_W-1:0]    s_lane1_value,
    input  logic signed [rlcc_pkg::LANE_W-1:0]    s_lane2_value,
    input  logic signed [rlcc_pkg::LANE_W-1:0]    s_lane3_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [rlcc_pkg::LANE_W-1:0]    m_out_lane0,
    output logic signed [rlcc_pkg::LANE_W-1:0]    m_out_lane1,
    output logic signed [rlcc_pkg::LANE_W-1:0]    m_out_lane2,
    output logic signed [rlcc_pkg::LANE_W-1:0]    m_out_lane3,
    output logic                                  m_last_pixel
);

    localparam int LW = rlcc_pkg::LANE_W;

    logic [rlcc_pkg::FMT_W-1:0]  fmt_reg;
    logic                        reg_hit;
    logic                        b_open;
    rlcc_pkg::issue_t            req;
    rlcc_pkg::tbl_wr_t           tbl_wr;
    rlcc_pkg::pal_wr_t           pal_wr;
    logic [rlcc_pkg::WORD_W-1:0] r_word, g_word, b_word, pal_word, m_word;

    // Register file: only pixel_format lives here
    assign pready  = 1'b1;
    assign reg_hit = (paddr[rlcc_pkg::ADDR_W-1:2] == rlcc_pkg::REG_PIXEL_FORMAT);
    assign prdata  = reg_hit ? {{(rlcc_pkg::DATA_W-rlcc_pkg::FMT_W){1'b0}}, fmt_reg}
                             : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= rlcc_pkg::FMT_BGR;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            fmt_reg <= pwdata[rlcc_pkg::FMT_W-1:0];
        end
    end

    // Item stage: hold the request, step through packed indices, issue lookups and table writes
    rlcc_issue u_issue (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_pixel_bytes  (s_pixel_bytes),
        .s_table_select (s_table_select),
        .s_entry_index  (s_entry_index),
        .s_lane_word    ({s_lane3_value, s_lane2_value, s_lane1_value, s_lane0_value}),
        .pixel_format   (fmt_reg),
        .b_open         (b_open),
        .req            (req),
        .tbl_wr         (tbl_wr)
    );

    // Lookup stage: three channel tables read in parallel, registered output
    rlcc_chan_tables u_tables (
        .aclk   (aclk),
        .wr     (tbl_wr),
        .rd_en  (req.rd_tables),
        .r_addr (req.r_addr),
        .g_addr (req.g_addr),
        .b_addr (req.b_addr),
        .r_word (r_word),
        .g_word (g_word),
        .b_word (b_word)
    );

    // Palette with write-to-read forwarding from the sum stage
    rlcc_palette u_palette (
        .aclk    (aclk),
        .wr      (pal_wr),
        .rd_en   (req.rd_palette),
        .rd_addr (req.pal_addr),
        .rd_word (pal_word)
    );

    // Sum stage and output register; palette writes commit from here
    rlcc_lane_sum u_sum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .r_word   (r_word),
        .g_word   (g_word),
        .b_word   (b_word),
        .pal_word (pal_word),
        .b_open   (b_open),
        .pal_wr   (pal_wr),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_word   (m_word),
        .m_last   (m_last_pixel)
    );

    assign m_out_lane0 = signed'(m_word[0*LW +: LW]);
    assign m_out_lane1 = signed'(m_word[1*LW +: LW]);
    assign m_out_lane2 = signed'(m_word[2*LW +: LW]);
    assign m_out_lane3 = signed'(m_word[3*LW +: LW]);

endmodule

### design/rlcc_issue.sv
module rlcc_issue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_operation,
    input  logic [rlcc_pkg::PIX_W-1:0]    s_pixel_bytes,
    input  logic [1:0]                    s_table_select,
    input  logic [rlcc_pkg::IDX_W-1:0]    s_entry_index,
    input  logic [rlcc_pkg::WORD_W-1:0]   s_lane_word,
    input  logic [rlcc_pkg::FMT_W-1:0]    pixel_format,
    input  logic                          b_open,
    output rlcc_pkg::issue_t              req,
    output rlcc_pkg::tbl_wr_t             tbl_wr
);

    logic                          a_valid_reg;
    logic [1:0]                    op_reg;
    logic [rlcc_pkg::PIX_W-1:0]    pix_reg;
    logic [1:0]                    sel_reg;
    logic [rlcc_pkg::IDX_W-1:0]    idx_reg;
    logic [rlcc_pkg::WORD_W-1:0]   lanes_reg;
    logic [2:0]                    cnt_reg;

    logic       fire;
    logic       done;
    logic       emit;
    logic [2:0] last_cnt;
    logic [7:0] byte0, byte1, byte2;
    logic [7:0] shifted;
    logic [15:0] c16;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        widen5 = {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        widen6 = {v, v[5:4]};
    endfunction

    assign byte0 = pix_reg[7:0];
    assign byte1 = pix_reg[15:8];
    assign byte2 = pix_reg[23:16];
    assign c16   = pix_reg[15:0];
    assign fire  = a_valid_reg && b_open;

    always_comb begin
        emit     = 1'b0;
        last_cnt = 3'd0;
        shifted  = 8'd0;
        req      = '0;
        tbl_wr   = '0;
        case (rlcc_pkg::op_t'(op_reg))
            rlcc_pkg::OP_CONVERT: begin
                case (rlcc_pkg::fmt_t'(pixel_format))
                    rlcc_pkg::FMT_BGR: begin
                        emit = 1'b1;
                        req.r_addr = byte2;
                        req.g_addr = byte1;
                        req.b_addr = byte0;
                    end
                    rlcc_pkg::FMT_RGB: begin
                        emit = 1'b1;
                        req.r_addr = byte0;
                        req.g_addr = byte1;
                        req.b_addr = byte2;
                    end
                    rlcc_pkg::FMT_B5G5R5: begin
                        emit = 1'b1;
                        req.r_addr = widen5(c16[14:10]);
                        req.g_addr = widen5(c16[9:5]);
                        req.b_addr = widen5(c16[4:0]);
                    end
                    rlcc_pkg::FMT_B5G6R5: begin
                        emit = 1'b1;
                        req.r_addr = widen5(c16[15:11]);
                        req.g_addr = widen6(c16[10:5]);
                        req.b_addr = widen5(c16[4:0]);
                    end
                    rlcc_pkg::FMT_GRAY: begin
                        emit = 1'b1;
                        req.r_addr = byte0;
                        req.g_addr = byte0;
                        req.b_addr = byte0;
                    end
                    rlcc_pkg::FMT_INDEX8: begin
                        emit = 1'b1;
                        req.from_palette = 1'b1;
                        req.pal_addr = byte0;
                    end
                    rlcc_pkg::FMT_INDEX4: begin
                        emit = 1'b1;
                        req.from_palette = 1'b1;
                        last_cnt = 3'd1;
                        shifted = byte0 << {cnt_reg[0], 2'b00};
                        req.pal_addr = {4'd0, shifted[7:4]};
                    end
                    rlcc_pkg::FMT_INDEX2: begin
                        emit = 1'b1;
                        req.from_palette = 1'b1;
                        last_cnt = 3'd3;
                        shifted = byte0 << {cnt_reg[1:0], 1'b0};
                        req.pal_addr = {6'd0, shifted[7:6]};
                    end
                    rlcc_pkg::FMT_INDEX1: begin
                        emit = 1'b1;
                        req.from_palette = 1'b1;
                        last_cnt = 3'd7;
                        shifted = byte0 << cnt_reg;
                        req.pal_addr = {7'd0, shifted[7]};
                    end
                    default: begin
                        emit = 1'b0;
                    end
                endcase
            end
            rlcc_pkg::OP_TABLE_WR: begin
                tbl_wr.en   = fire && (sel_reg != 2'd3);
                tbl_wr.sel  = sel_reg;
                tbl_wr.addr = idx_reg;
                tbl_wr.data = lanes_reg;
            end
            rlcc_pkg::OP_PALETTE_WR: begin
                req.pal_write  = 1'b1;
                req.r_addr     = byte2;
                req.g_addr     = byte1;
                req.b_addr     = byte0;
                req.pal_wr_idx = idx_reg;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        done           = (cnt_reg == last_cnt);
        req.last       = done;
        req.enter      = fire && (emit || req.pal_write);
        req.rd_palette = req.enter && req.from_palette;
        req.rd_tables  = req.enter && !req.from_palette;
    end

    assign s_ready = !a_valid_reg || (fire && done);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            cnt_reg     <= 3'd0;
        end else if (s_valid && s_ready) begin
            a_valid_reg <= 1'b1;
            cnt_reg     <= 3'd0;
        end else if (fire && done) begin
            a_valid_reg <= 1'b0;
        end else if (fire) begin
            cnt_reg <= cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg    <= s_operation;
            pix_reg   <= s_pixel_bytes;
            sel_reg   <= s_table_select;
            idx_reg   <= s_entry_index;
            lanes_reg <= s_lane_word;
        end
    end

endmodule

### design/rlcc_chan_tables.sv
module rlcc_chan_tables (
    input  logic                        aclk,
    input  rlcc_pkg::tbl_wr_t           wr,
    input  logic                        rd_en,
    input  logic [rlcc_pkg::IDX_W-1:0]  r_addr,
    input  logic [rlcc_pkg::IDX_W-1:0]  g_addr,
    input  logic [rlcc_pkg::IDX_W-1:0]  b_addr,
    output logic [rlcc_pkg::WORD_W-1:0] r_word,
    output logic [rlcc_pkg::WORD_W-1:0] g_word,
    output logic [rlcc_pkg::WORD_W-1:0] b_word
);

    localparam int DEPTH = 1 << rlcc_pkg::IDX_W;

    logic [rlcc_pkg::WORD_W-1:0] red_mem   [DEPTH];
    logic [rlcc_pkg::WORD_W-1:0] green_mem [DEPTH];
    logic [rlcc_pkg::WORD_W-1:0] blue_mem  [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            case (rlcc_pkg::table_sel_t'(wr.sel))
                rlcc_pkg::SEL_RED:   red_mem[wr.addr]   <= wr.data;
                rlcc_pkg::SEL_GREEN: green_mem[wr.addr] <= wr.data;
                rlcc_pkg::SEL_BLUE:  blue_mem[wr.addr]  <= wr.data;
                default: ;
            endcase
        end
        if (rd_en) begin
            r_word <= red_mem[r_addr];
            g_word <= green_mem[g_addr];
            b_word <= blue_mem[b_addr];
        end
    end

endmodule

### design/rlcc_palette.sv
module rlcc_palette (
    input  logic                        aclk,
    input  rlcc_pkg::pal_wr_t           wr,
    input  logic                        rd_en,
    input  logic [rlcc_pkg::IDX_W-1:0]  rd_addr,
    output logic [rlcc_pkg::WORD_W-1:0] rd_word
);

    localparam int DEPTH = 1 << rlcc_pkg::IDX_W;

    logic [rlcc_pkg::WORD_W-1:0] pal_mem [DEPTH];
    logic [rlcc_pkg::WORD_W-1:0] q_reg;
    logic [rlcc_pkg::WORD_W-1:0] fwd_reg;
    logic                        hit_reg;

    // A read that meets a write to the same entry takes the new word
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            pal_mem[wr.addr] <= wr.data;
        end
        if (rd_en) begin
            q_reg   <= pal_mem[rd_addr];
            fwd_reg <= wr.data;
            hit_reg <= wr.en && (wr.addr == rd_addr);
        end
    end

    assign rd_word = hit_reg ? fwd_reg : q_reg;

endmodule

### design/rlcc_lane_sum.sv
module rlcc_lane_sum (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rlcc_pkg::issue_t            req,
    input  logic [rlcc_pkg::WORD_W-1:0] r_word,
    input  logic [rlcc_pkg::WORD_W-1:0] g_word,
    input  logic [rlcc_pkg::WORD_W-1:0] b_word,
    input  logic [rlcc_pkg::WORD_W-1:0] pal_word,
    output logic                        b_open,
    output rlcc_pkg::pal_wr_t           pal_wr,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rlcc_pkg::WORD_W-1:0] m_word,
    output logic                        m_last
);

    localparam int LW = rlcc_pkg::LANE_W;
    localparam int SW = rlcc_pkg::SUM_W;

    logic                        b_valid_reg;
    logic                        b_pal_src_reg;
    logic                        b_palwr_reg;
    logic                        b_last_reg;
    logic [rlcc_pkg::IDX_W-1:0]  b_idx_reg;
    logic                        c_valid_reg;
    logic [rlcc_pkg::WORD_W-1:0] c_word_reg;
    logic                        c_last_reg;

    logic                        c_free;
    logic                        b_adv;
    logic [rlcc_pkg::WORD_W-1:0] sum_word;
    logic [rlcc_pkg::WORD_W-1:0] b_word_out;
    logic signed [SW-1:0]        lane_sum [rlcc_pkg::LANES];

    always_comb begin
        for (int k = 0; k < rlcc_pkg::LANES; k++) begin
            lane_sum[k] = SW'(signed'(r_word[k*LW +: LW]))
                        + SW'(signed'(g_word[k*LW +: LW]))
                        + SW'(signed'(b_word[k*LW +: LW]));
            if (lane_sum[k] > rlcc_pkg::LANE_MAX) begin
                sum_word[k*LW +: LW] = rlcc_pkg::LANE_MAX[LW-1:0];
            end else if (lane_sum[k] < rlcc_pkg::LANE_MIN) begin
                sum_word[k*LW +: LW] = rlcc_pkg::LANE_MIN[LW-1:0];
            end else begin
                sum_word[k*LW +: LW] = lane_sum[k][LW-1:0];
            end
        end
    end

    assign b_word_out  = b_pal_src_reg ? pal_word : sum_word;
    assign c_free      = !c_valid_reg || m_ready;
    assign b_adv       = b_valid_reg && (b_palwr_reg || c_free);
    assign b_open      = !b_valid_reg || b_adv;
    assign pal_wr.en   = b_valid_reg && b_palwr_reg;
    assign pal_wr.addr = b_idx_reg;
    assign pal_wr.data = sum_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (b_open) begin
                b_valid_reg <= req.enter;
            end
            if (b_adv && !b_palwr_reg) begin
                c_valid_reg <= 1'b1;
            end else if (m_ready) begin
                c_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b_open && req.enter) begin
            b_pal_src_reg <= req.from_palette;
            b_palwr_reg   <= req.pal_write;
            b_last_reg    <= req.last;
            b_idx_reg     <= req.pal_wr_idx;
        end
        if (b_adv && !b_palwr_reg) begin
            c_word_reg <= b_word_out;
            c_last_reg <= b_last_reg;
        end
    end

    assign m_valid = c_valid_reg;
    assign m_word  = c_word_reg;
    assign m_last  = c_last_reg;

endmodule
